[src/iqtm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtm_pkg: shared types and constants
// Word kinds, register indexes, command and status groups, and the small
// arithmetic helpers used by the I/Q time match and correction block.
// ----------------------------------------------------------------------------
package iqtm_pkg;

   localparam int TIME_W  = 62;
   localparam int VAL_W   = 32;
   localparam int ENTRY_W = TIME_W + VAL_W;
   localparam int IDX_W   = 10;
   localparam int ANG_W   = 16;
   localparam int CSR_W   = 3;
   localparam int CORD_W  = 36;
   localparam int Z_W     = 18;
   localparam int NSTEPS  = 15;
   localparam int ROOT_STEPS = 32;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_APP_I = 2'd1;
   localparam logic [1:0] KIND_APP_Q = 2'd2;
   localparam logic [1:0] KIND_QUERY = 2'd3;

   localparam logic [CSR_W-1:0] CSR_BIAS_I     = 3'd0;
   localparam logic [CSR_W-1:0] CSR_BIAS_Q     = 3'd1;
   localparam logic [CSR_W-1:0] CSR_GAIN_RECIP = 3'd2;
   localparam logic [CSR_W-1:0] CSR_CROSS_COEF = 3'd3;
   localparam logic [CSR_W-1:0] CSR_QUAD_SCALE = 3'd4;
   localparam logic [CSR_W-1:0] CSR_FLIP_PHASE = 3'd5;

   localparam logic signed [VAL_W-1:0] ONE_Q24 = 32'sd16777216;

   typedef struct packed {
      logic clear;
      logic app_i;
      logic app_q;
      logic take;
      logic rd_idx;
      logic cap_i;
      logic issue_q;
      logic rd_qbest;
      logic cap_q;
      logic issue_i;
      logic bias;
      logic mul;
      logic rnd;
      logic sq;
      logic init;
      logic iter;
      logic load_out;
      logic load_zero;
   } iqtm_cmd_type;

   typedef struct packed {
      logic no_query;
      logic last_q;
      logic last_i;
      logic mismatch;
   } iqtm_stat_type;

   // Arctangent of 2^-k in units of pi/32768.
   function automatic logic [ANG_W-1:0] iqtm_atan(input logic [3:0] k);
      logic [ANG_W-1:0] r;
      unique case (k)
         4'd0:  r = 16'd8192;
         4'd1:  r = 16'd4836;
         4'd2:  r = 16'd2555;
         4'd3:  r = 16'd1297;
         4'd4:  r = 16'd651;
         4'd5:  r = 16'd326;
         4'd6:  r = 16'd163;
         4'd7:  r = 16'd81;
         4'd8:  r = 16'd41;
         4'd9:  r = 16'd20;
         4'd10: r = 16'd10;
         4'd11: r = 16'd5;
         4'd12: r = 16'd3;
         4'd13: r = 16'd1;
         4'd14: r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] iqtm_sat_sub(
      input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] d;
      logic signed [VAL_W-1:0] r;
      d = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
      if (d[VAL_W] != d[VAL_W-1]) begin
         r = d[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         r = d[VAL_W-1:0];
      end
      return r;
   endfunction

   // Round (p1 + p2) / 2^24 half up, then saturate to 32 bits.
   function automatic logic signed [VAL_W-1:0] iqtm_round_sat(
      input logic signed [63:0] p1, input logic signed [63:0] p2);
      logic signed [64:0] s;
      logic signed [64:0] sh;
      logic signed [40:0] r;
      logic signed [VAL_W-1:0] o;
      s  = $signed({p1[63], p1}) + $signed({p2[63], p2}) + 65'sd8388608;
      sh = s >>> 24;
      r  = sh[40:0];
      if (r > 41'sd2147483647) begin
         o = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (r < -41'sd2147483648) begin
         o = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         o = r[VAL_W-1:0];
      end
      return o;
   endfunction

endpackage

[src/iqtm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtm_ctrl: sequencing state machine
// Accepts words, steps the datapath through both store scans and the
// arithmetic, and holds the result valid flag.
// ----------------------------------------------------------------------------
module iqtm_ctrl #(
   parameter int DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output iqtm_pkg::iqtm_cmd_type cmd,
   input  iqtm_pkg::iqtm_stat_type stat,
   output logic [((($clog2(DEPTH)) > 6) ? $clog2(DEPTH) : 6)-1:0] cnt
);
   import iqtm_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = (AW > 6) ? AW : 6;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_START = 5'd1;
   localparam logic [4:0] S_CAPI  = 5'd2;
   localparam logic [4:0] S_SCANQ = 5'd3;
   localparam logic [4:0] S_QD1   = 5'd4;
   localparam logic [4:0] S_QD2   = 5'd5;
   localparam logic [4:0] S_RDQ   = 5'd6;
   localparam logic [4:0] S_CAPQ  = 5'd7;
   localparam logic [4:0] S_SCANI = 5'd8;
   localparam logic [4:0] S_ID1   = 5'd9;
   localparam logic [4:0] S_ID2   = 5'd10;
   localparam logic [4:0] S_CHK   = 5'd11;
   localparam logic [4:0] S_BIAS  = 5'd12;
   localparam logic [4:0] S_MUL   = 5'd13;
   localparam logic [4:0] S_RND   = 5'd14;
   localparam logic [4:0] S_SQ    = 5'd15;
   localparam logic [4:0] S_INIT  = 5'd16;
   localparam logic [4:0] S_ITER  = 5'd17;
   localparam logic [4:0] S_OUT   = 5'd18;

   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || (req_kind != KIND_QUERY));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign cnt       = cnt_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_CLEAR: cmd.clear = 1'b1;
                  KIND_APP_I: cmd.app_i = 1'b1;
                  KIND_APP_Q: cmd.app_q = 1'b1;
                  default: begin
                     cmd.take = 1'b1;
                     state_in = S_START;
                  end
               endcase
            end
         end
         S_START: begin
            if (stat.no_query) begin
               cmd.load_zero = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rd_idx = 1'b1;
               state_in   = S_CAPI;
            end
         end
         S_CAPI: begin
            cmd.cap_i = 1'b1;
            cnt_in    = '0;
            state_in  = S_SCANQ;
         end
         S_SCANQ: begin
            cmd.issue_q = 1'b1;
            if (stat.last_q) begin
               cnt_in   = '0;
               state_in = S_QD1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_QD1: state_in = S_QD2;
         S_QD2: state_in = S_RDQ;
         S_RDQ: begin
            cmd.rd_qbest = 1'b1;
            state_in     = S_CAPQ;
         end
         S_CAPQ: begin
            cmd.cap_q = 1'b1;
            cnt_in    = '0;
            state_in  = S_SCANI;
         end
         S_SCANI: begin
            cmd.issue_i = 1'b1;
            if (stat.last_i) begin
               cnt_in   = '0;
               state_in = S_ID1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ID1: state_in = S_ID2;
         S_ID2: state_in = S_CHK;
         S_CHK: begin
            if (stat.mismatch) begin
               cmd.load_zero = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_BIAS;
            end
         end
         S_BIAS: begin
            cmd.bias = 1'b1;
            cnt_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            if (cnt_ff == CW'(2)) begin
               cnt_in   = '0;
               state_in = S_RND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            cnt_in   = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.sq = 1'b1;
            if (cnt_ff == CW'(1)) begin
               cnt_in   = '0;
               state_in = S_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            cnt_in   = '0;
            state_in = S_ITER;
         end
         S_ITER: begin
            cmd.iter = 1'b1;
            if (cnt_ff == CW'(ROOT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            cmd.load_out = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/iqtm_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtm_dpath: stores, scan pipeline and correction arithmetic
// Holds both sample stores, the configuration registers, the nearest-time
// scan, a shared multiplier, the square root and the CORDIC unit.
// ----------------------------------------------------------------------------
module iqtm_dpath #(
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  iqtm_pkg::iqtm_cmd_type            cmd,
   output iqtm_pkg::iqtm_stat_type           stat,
   input  logic [((($clog2(DEPTH)) > 6) ? $clog2(DEPTH) : 6)-1:0] cnt,
   input  logic [iqtm_pkg::TIME_W-1:0]       req_entry_time,
   input  logic signed [iqtm_pkg::VAL_W-1:0] req_entry_value,
   input  logic [iqtm_pkg::IDX_W-1:0]        req_query_index,
   input  logic                              csr_write_enable,
   input  logic [iqtm_pkg::CSR_W-1:0]        csr_index,
   input  logic [iqtm_pkg::VAL_W-1:0]        csr_write_data,
   output logic                              rsp_matched,
   output logic [iqtm_pkg::TIME_W-1:0]       rsp_mid_time,
   output logic signed [iqtm_pkg::VAL_W-1:0] rsp_inphase_out,
   output logic signed [iqtm_pkg::VAL_W-1:0] rsp_quad_out,
   output logic [iqtm_pkg::VAL_W-1:0]        rsp_magnitude,
   output logic signed [iqtm_pkg::ANG_W-1:0] rsp_angle
);
   import iqtm_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = (AW > 6) ? AW : 6;
   localparam int NW = $clog2(DEPTH + 1);
   localparam int QW = (NW > IDX_W) ? NW : IDX_W;

   // Configuration registers.
   logic signed [VAL_W-1:0] bias_i_ff, bias_q_ff, gain_ff, cross_ff, quad_ff;
   logic                    flip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_i_ff <= '0;
         bias_q_ff <= '0;
         gain_ff   <= ONE_Q24;
         cross_ff  <= '0;
         quad_ff   <= ONE_Q24;
         flip_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BIAS_I:     bias_i_ff <= csr_write_data;
            CSR_BIAS_Q:     bias_q_ff <= csr_write_data;
            CSR_GAIN_RECIP: gain_ff   <= csr_write_data;
            CSR_CROSS_COEF: cross_ff  <= csr_write_data;
            CSR_QUAD_SCALE: quad_ff   <= csr_write_data;
            CSR_FLIP_PHASE: flip_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Stores and fill counts.
   logic [ENTRY_W-1:0] i_mem [DEPTH];
   logic [ENTRY_W-1:0] q_mem [DEPTH];
   logic [ENTRY_W-1:0] i_rd_ff, q_rd_ff;
   logic [NW-1:0]      i_count_ff, q_count_ff;
   logic               i_full, q_full;
   logic [AW-1:0]      scan_addr, i_addr, q_addr, qbest_ff, ibest_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [AW-1:0]      idx_addr;
   logic [NW:0]        scan_next;

   assign i_full    = (i_count_ff == NW'(DEPTH));
   assign q_full    = (q_count_ff == NW'(DEPTH));
   assign scan_addr = cnt[AW-1:0];
   assign idx_addr  = AW'(idx_ff);
   assign i_addr    = cmd.rd_idx ? idx_addr : scan_addr;
   assign q_addr    = cmd.rd_qbest ? qbest_ff : scan_addr;
   assign scan_next = (NW+1)'(scan_addr) + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_count_ff <= '0;
         q_count_ff <= '0;
      end else if (cmd.clear) begin
         i_count_ff <= '0;
         q_count_ff <= '0;
      end else begin
         if (cmd.app_i && !i_full) i_count_ff <= i_count_ff + 1'b1;
         if (cmd.app_q && !q_full) q_count_ff <= q_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.app_i && !i_full) begin
         i_mem[i_count_ff[AW-1:0]] <= {req_entry_time, req_entry_value};
      end
      i_rd_ff <= i_mem[i_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.app_q && !q_full) begin
         q_mem[q_count_ff[AW-1:0]] <= {req_entry_time, req_entry_value};
      end
      q_rd_ff <= q_mem[q_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.take) idx_ff <= req_query_index;
   end

   // Captured entries.
   logic [TIME_W-1:0]       ti_ff, tq_ff, ref_ff;
   logic signed [VAL_W-1:0] vi_ff, vq_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap_i) begin
         ti_ff  <= i_rd_ff[ENTRY_W-1:VAL_W];
         vi_ff  <= i_rd_ff[VAL_W-1:0];
         ref_ff <= i_rd_ff[ENTRY_W-1:VAL_W];
      end
      if (cmd.cap_q) begin
         tq_ff  <= q_rd_ff[ENTRY_W-1:VAL_W];
         vq_ff  <= q_rd_ff[VAL_W-1:0];
         ref_ff <= q_rd_ff[ENTRY_W-1:VAL_W];
      end
   end

   // Nearest-time scan: read, distance, compare.
   logic              v1_ff, m1_ff, v2_ff, m2_ff;
   logic [AW-1:0]     tag1_ff, tag2_ff;
   logic [TIME_W-1:0] d_ff, best_ff, s1_time;
   logic              take_best;

   assign s1_time   = m1_ff ? i_rd_ff[ENTRY_W-1:VAL_W] : q_rd_ff[ENTRY_W-1:VAL_W];
   assign take_best = v2_ff && ((tag2_ff == '0) || (m2_ff ? (d_ff < best_ff)
                                                         : (d_ff <= best_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue_q || cmd.issue_i;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_ff   <= cmd.issue_i;
      tag1_ff <= scan_addr;
      m2_ff   <= m1_ff;
      tag2_ff <= tag1_ff;
      d_ff    <= (ref_ff > s1_time) ? (ref_ff - s1_time) : (s1_time - ref_ff);
      if (take_best) begin
         best_ff <= d_ff;
         if (m2_ff) ibest_ff <= tag2_ff;
         else       qbest_ff <= tag2_ff;
      end
   end

   assign stat.no_query = (i_count_ff == '0) || (q_count_ff == '0) ||
                          (QW'(idx_ff) >= QW'(i_count_ff));
   assign stat.last_q   = (scan_next == {1'b0, q_count_ff});
   assign stat.last_i   = (scan_next == {1'b0, i_count_ff});
   assign stat.mismatch = (ibest_ff != idx_addr);

   // Correction arithmetic with one shared multiplier.
   logic signed [VAL_W-1:0] di_ff, dq_ff, io_ff, qo_ff, mul_a, mul_b;
   logic signed [63:0]      prod, p0_ff, p1_ff, p2_ff;

   always_comb begin
      if (cmd.sq) begin
         mul_a = cnt[0] ? qo_ff : io_ff;
         mul_b = mul_a;
      end else begin
         unique case (cnt[1:0])
            2'd0: begin
               mul_a = gain_ff;
               mul_b = di_ff;
            end
            2'd1: begin
               mul_a = cross_ff;
               mul_b = di_ff;
            end
            default: begin
               mul_a = quad_ff;
               mul_b = dq_ff;
            end
         endcase
      end
   end

   assign prod = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.bias) begin
         di_ff <= iqtm_sat_sub(vi_ff, bias_i_ff);
         dq_ff <= iqtm_sat_sub(vq_ff, bias_q_ff);
      end
      if (cmd.mul) begin
         unique case (cnt[1:0])
            2'd0:    p0_ff <= prod;
            2'd1:    p1_ff <= prod;
            default: p2_ff <= prod;
         endcase
      end
      if (cmd.sq) begin
         if (cnt[0]) p1_ff <= prod;
         else        p0_ff <= prod;
      end
      if (cmd.rnd) begin
         io_ff <= iqtm_round_sat(p0_ff, 64'sd0);
         qo_ff <= iqtm_round_sat(p1_ff, p2_ff);
      end
   end

   // Square root, one result bit per step.
   logic [63:0] rad_ff, root_ff, bit_ff, trial;
   assign trial = root_ff + bit_ff;

   // CORDIC vectoring.
   logic signed [CORD_W-1:0] x_ff, y_ff, xs, ys, io_w, qo_w;
   logic signed [Z_W-1:0]    z_ff, atan_w;
   logic                     cord_on;

   assign io_w    = CORD_W'(io_ff);
   assign qo_w    = CORD_W'(qo_ff);
   assign xs      = x_ff >>> cnt[3:0];
   assign ys      = y_ff >>> cnt[3:0];
   assign atan_w  = $signed(Z_W'(iqtm_atan(cnt[3:0])));
   assign cord_on = (cnt < CW'(NSTEPS));

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         rad_ff  <= 64'(p0_ff) + 64'(p1_ff);
         root_ff <= '0;
         bit_ff  <= 64'h4000_0000_0000_0000;
         if (io_ff < 0) begin
            if (qo_ff >= 0) begin
               x_ff <= qo_w;
               y_ff <= -io_w;
               z_ff <= 18'sd16384;
            end else begin
               x_ff <= -qo_w;
               y_ff <= io_w;
               z_ff <= -18'sd16384;
            end
         end else begin
            x_ff <= io_w;
            y_ff <= qo_w;
            z_ff <= '0;
         end
      end
      if (cmd.iter) begin
         if (rad_ff >= trial) begin
            rad_ff  <= rad_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         if (cord_on) begin
            if (y_ff > 0) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_w;
            end else if (y_ff < 0) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_w;
            end
         end
      end
   end

   // Result word.
   logic [TIME_W:0] tsum;
   assign tsum = (TIME_W+1)'(ti_ff) + (TIME_W+1)'(tq_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_zero) begin
         rsp_matched     <= 1'b0;
         rsp_mid_time    <= '0;
         rsp_inphase_out <= '0;
         rsp_quad_out    <= '0;
         rsp_magnitude   <= '0;
         rsp_angle       <= '0;
      end else if (cmd.load_out) begin
         rsp_matched     <= 1'b1;
         rsp_mid_time    <= tsum[TIME_W:1];
         rsp_inphase_out <= io_ff;
         rsp_quad_out    <= qo_ff;
         rsp_magnitude   <= root_ff[VAL_W-1:0];
         rsp_angle       <= flip_ff ? -z_ff[ANG_W-1:0] : z_ff[ANG_W-1:0];
      end
   end

endmodule

[src/iq_time_match_correct.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_time_match_correct: I/Q time matching and imbalance correction
// Appends timestamped I and Q samples, answers queries with a mutual
// nearest-time match, bias and gain/phase correction, magnitude and phase.
// ----------------------------------------------------------------------------
// Clear and append words produce no result word. A query with an empty store
// or an index at or past the I fill count is answered without a scan, with a
// zeroed, unmatched result word. The time of a full query is set by the two
// scans over the single-port stores and the 32-step square root.
// One query is worked on at a time. Reset clears both fill counts and loads
// the register defaults; store contents are not cleared.
module iq_time_match_correct #(
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic [iqtm_pkg::TIME_W-1:0]       req_entry_time,
   input  logic signed [iqtm_pkg::VAL_W-1:0] req_entry_value,
   input  logic [iqtm_pkg::IDX_W-1:0]        req_query_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_matched,
   output logic [iqtm_pkg::TIME_W-1:0]       rsp_mid_time,
   output logic signed [iqtm_pkg::VAL_W-1:0] rsp_inphase_out,
   output logic signed [iqtm_pkg::VAL_W-1:0] rsp_quad_out,
   output logic [iqtm_pkg::VAL_W-1:0]        rsp_magnitude,
   output logic signed [iqtm_pkg::ANG_W-1:0] rsp_angle,
   input  logic                              csr_write_enable,
   input  logic [iqtm_pkg::CSR_W-1:0]        csr_index,
   input  logic [iqtm_pkg::VAL_W-1:0]        csr_write_data
);
   import iqtm_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = (AW > 6) ? AW : 6;

   // The controller owns the sequence and the shared step counter; the
   // datapath owns every store, configuration register and arithmetic unit.
   iqtm_cmd_type  cmd;
   iqtm_stat_type stat;
   logic [CW-1:0] cnt;

   iqtm_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat),
      .cnt       (cnt)
   );

   // The result word is held in the datapath output registers until the
   // consumer takes it; a new query is only accepted once it has gone.
   iqtm_dpath #(
      .DEPTH(DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .cnt              (cnt),
      .req_entry_time   (req_entry_time),
      .req_entry_value  (req_entry_value),
      .req_query_index  (req_query_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_matched      (rsp_matched),
      .rsp_mid_time     (rsp_mid_time),
      .rsp_inphase_out  (rsp_inphase_out),
      .rsp_quad_out     (rsp_quad_out),
      .rsp_magnitude    (rsp_magnitude),
      .rsp_angle        (rsp_angle)
   );

endmodule
